/* rtl/core/bf_pkg.sv */
package bf_pkg;

    localparam int ROUNDS_DEF = 16;
    localparam int P_DEPTH    = 18;
    localparam int BOX_SIZE   = 256;
    localparam int BOX_BITS   = 8;
    localparam int P_BITS     = 5;

    typedef enum logic [2:0] {
        CMD_WRITE_P  = 3'd0,
        CMD_WRITE_S  = 3'd1,
        CMD_XOR_P    = 3'd2,
        CMD_EXPAND   = 3'd3,
        CMD_ENCRYPT  = 3'd4,
        CMD_DECRYPT  = 3'd5,
        CMD_LOAD_OFB = 3'd6,
        CMD_OFB_STEP = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SREAD,
        ST_ROUND,
        ST_FINAL,
        ST_STORE,
        ST_OUT
    } state_t;

endpackage

/* rtl/core/bf_ram.sv */
module bf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/blowfish_cipher_engine.sv */
// blowfish block cipher engine, one command per input transfer
// input channel: in_valid/in_ready with command, entry_index, box_select,
// table_word and block_in; output channel: out_valid/out_ready with block_out
// and status. every command yields exactly one output transfer.
// the round loop shares one f-function unit and four s-box rams: each round
// does an s-box read, then add/xor/add and half swap. one command at a time:
// in_ready is low from acceptance until its result is transferred out and
// rises the cycle after.
// reset clears the sequencer and the ofb register; p and s tables are
// undefined until software writes them.
// if the receiver stalls, the result holds in the output register and the
// engine waits with in_ready low.
module blowfish_cipher_engine #(
    parameter int ROUNDS = bf_pkg::ROUNDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [7:0]  entry_index,
    input  logic [1:0]  box_select,
    input  logic [31:0] table_word,
    input  logic [63:0] block_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] block_out,
    output logic        status
);

    localparam int PB = bf_pkg::P_BITS;
    localparam int RB = $clog2(ROUNDS + 1);

    bf_pkg::state_t state_reg, state_next;
    bf_pkg::cmd_t   cmd_reg, cmd_next;
    logic [31:0] p_reg [bf_pkg::P_DEPTH];
    logic [31:0] l_reg, l_next, r_reg, r_next;
    logic [63:0] ofb_reg, ofb_next;
    logic [63:0] data_reg, data_next;
    logic [63:0] out_reg, out_next;
    logic        status_reg, status_next;
    logic [RB-1:0] rnd_reg, rnd_next;
    logic [10:0] ecnt_reg, ecnt_next;   // expansion word pair counter
    logic        p_we;
    logic [PB-1:0] p_waddr, p_waddr2;
    logic [31:0] p_wdata, p_wdata2;
    logic        p_we2;
    logic [PB-1:0] p_rsel;
    logic [31:0] l_x;
    logic [31:0] s0, s1, s2, s3;
    logic [31:0] f_val;
    logic        s_we;
    logic [1:0]  s_wbox;
    logic [7:0]  s_waddr;
    logic [31:0] s_wdata;
    logic [7:0]  ra0, ra1, ra2, ra3;
    logic        idx_bad;

    assign idx_bad = (entry_index > 8'(bf_pkg::P_DEPTH - 1));

    // round key pointer
    always_comb
    begin
        if (cmd_reg == bf_pkg::CMD_DECRYPT)
            p_rsel = PB'(ROUNDS + 1) - PB'(rnd_reg);
        else
            p_rsel = PB'(rnd_reg);
    end

    assign l_x = l_reg ^ p_reg[p_rsel];
    assign ra0 = l_x[31:24];
    assign ra1 = l_x[23:16];
    assign ra2 = l_x[15:8];
    assign ra3 = l_x[7:0];
    assign f_val = ((s0 + s1) ^ s2) + s3;

    bf_ram #(.WIDTH(32), .DEPTH(bf_pkg::BOX_SIZE)) u_s0 (.clk(clk),
        .we(s_we && s_wbox == 2'd0), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(ra0), .rdata(s0));
    bf_ram #(.WIDTH(32), .DEPTH(bf_pkg::BOX_SIZE)) u_s1 (.clk(clk),
        .we(s_we && s_wbox == 2'd1), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(ra1), .rdata(s1));
    bf_ram #(.WIDTH(32), .DEPTH(bf_pkg::BOX_SIZE)) u_s2 (.clk(clk),
        .we(s_we && s_wbox == 2'd2), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(ra2), .rdata(s2));
    bf_ram #(.WIDTH(32), .DEPTH(bf_pkg::BOX_SIZE)) u_s3 (.clk(clk),
        .we(s_we && s_wbox == 2'd3), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(ra3), .rdata(s3));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bf_pkg::ST_IDLE;
            ofb_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ofb_reg   <= ofb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        l_reg      <= l_next;
        r_reg      <= r_next;
        data_reg   <= data_next;
        out_reg    <= out_next;
        status_reg <= status_next;
        rnd_reg    <= rnd_next;
        ecnt_reg   <= ecnt_next;
        if (p_we)
            p_reg[p_waddr] <= p_wdata;
        if (p_we2)
            p_reg[p_waddr2] <= p_wdata2;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        data_next   = data_reg;
        out_next    = out_reg;
        status_next = status_reg;
        rnd_next    = rnd_reg;
        ecnt_next   = ecnt_reg;
        ofb_next    = ofb_reg;
        p_we        = 1'b0;
        p_waddr     = '0;
        p_wdata     = '0;
        p_we2       = 1'b0;
        p_waddr2    = '0;
        p_wdata2    = '0;
        s_we        = 1'b0;
        s_wbox      = '0;
        s_waddr     = '0;
        s_wdata     = '0;
        in_ready    = 1'b0;
        case (state_reg)
            bf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next    = bf_pkg::cmd_t'(command);
                    data_next   = block_in;
                    out_next    = '0;
                    status_next = 1'b0;
                    rnd_next    = '0;
                    ecnt_next   = '0;
                    state_next  = bf_pkg::ST_OUT;
                    case (bf_pkg::cmd_t'(command))
                        bf_pkg::CMD_WRITE_P:
                        begin
                            if (idx_bad)
                                status_next = 1'b1;
                            else
                            begin
                                p_we    = 1'b1;
                                p_waddr = PB'(entry_index);
                                p_wdata = table_word;
                            end
                        end
                        bf_pkg::CMD_XOR_P:
                        begin
                            if (idx_bad)
                                status_next = 1'b1;
                            else
                            begin
                                p_we    = 1'b1;
                                p_waddr = PB'(entry_index);
                                p_wdata = p_reg[PB'(entry_index)] ^ table_word;
                            end
                        end
                        bf_pkg::CMD_WRITE_S:
                        begin
                            s_we    = 1'b1;
                            s_wbox  = box_select;
                            s_waddr = entry_index;
                            s_wdata = table_word;
                        end
                        bf_pkg::CMD_LOAD_OFB:
                            ofb_next = block_in;
                        bf_pkg::CMD_EXPAND:
                        begin
                            l_next     = '0;
                            r_next     = '0;
                            state_next = bf_pkg::ST_SREAD;
                        end
                        bf_pkg::CMD_OFB_STEP:
                        begin
                            l_next     = ofb_reg[63:32];
                            r_next     = ofb_reg[31:0];
                            state_next = bf_pkg::ST_SREAD;
                        end
                        default:
                        begin
                            l_next     = block_in[63:32];
                            r_next     = block_in[31:0];
                            state_next = bf_pkg::ST_SREAD;
                        end
                    endcase
                end
            end
            bf_pkg::ST_PREP:
            begin
                rnd_next   = '0;
                state_next = bf_pkg::ST_SREAD;
            end
            bf_pkg::ST_SREAD:
                state_next = bf_pkg::ST_ROUND;   // s-box addresses from l^p
            bf_pkg::ST_ROUND:
            begin
                l_next   = r_reg ^ f_val;
                r_next   = l_x;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == RB'(ROUNDS - 1))
                    state_next = bf_pkg::ST_FINAL;
                else
                    state_next = bf_pkg::ST_SREAD;
            end
            bf_pkg::ST_FINAL:
            begin
                // undo last swap and whiten
                if (cmd_reg == bf_pkg::CMD_DECRYPT)
                begin
                    l_next = r_reg ^ p_reg[0];
                    r_next = l_reg ^ p_reg[1];
                end
                else
                begin
                    l_next = r_reg ^ p_reg[ROUNDS + 1];
                    r_next = l_reg ^ p_reg[ROUNDS];
                end
                state_next = bf_pkg::ST_STORE;
            end
            bf_pkg::ST_STORE:
            begin
                state_next = bf_pkg::ST_OUT;
                case (cmd_reg)
                    bf_pkg::CMD_EXPAND:
                    begin
                        if (ecnt_reg < 11'(bf_pkg::P_DEPTH / 2))
                        begin
                            p_we     = 1'b1;
                            p_waddr  = PB'({ecnt_reg[3:0], 1'b0});
                            p_wdata  = l_reg;
                            p_we2    = 1'b1;
                            p_waddr2 = PB'({ecnt_reg[3:0], 1'b1});
                            p_wdata2 = r_reg;
                            state_next = bf_pkg::ST_PREP;
                        end
                        else
                        begin
                            // two s words per pair: write left now, right next cycle
                            s_we    = 1'b1;
                            s_waddr = 8'(({1'b0, ecnt_reg} - 12'(bf_pkg::P_DEPTH / 2)) << 1);
                            s_wbox  = 2'(({1'b0, ecnt_reg} - 12'(bf_pkg::P_DEPTH / 2)) >> 7);
                            s_wdata = l_reg;
                            l_next  = r_reg;
                            r_next  = l_reg;
                            state_next = bf_pkg::ST_PREP;
                        end
                        ecnt_next = ecnt_reg + 1'b1;
                    end
                    bf_pkg::CMD_OFB_STEP:
                    begin
                        ofb_next = {l_reg, r_reg};
                        out_next = data_reg ^ {l_reg, r_reg};
                    end
                    default:
                        out_next = {l_reg, r_reg};
                endcase
            end
            bf_pkg::ST_OUT:
            begin
                if (out_ready)
                    state_next = bf_pkg::ST_IDLE;
            end
            default:
                state_next = bf_pkg::ST_IDLE;
        endcase
        // second half of an s pair in expansion: swapped halves wait in l/r
        if (state_reg == bf_pkg::ST_PREP && cmd_reg == bf_pkg::CMD_EXPAND
            && ecnt_reg > 11'(bf_pkg::P_DEPTH / 2))
        begin
            s_we    = 1'b1;
            s_waddr = 8'((({1'b0, ecnt_reg} - 12'(bf_pkg::P_DEPTH / 2 + 1)) << 1) + 12'd1);
            s_wbox  = 2'(({1'b0, ecnt_reg} - 12'(bf_pkg::P_DEPTH / 2 + 1)) >> 7);
            s_wdata = l_reg;
            l_next  = r_reg;
            r_next  = l_reg;
            if (ecnt_reg == 11'(bf_pkg::P_DEPTH / 2 + 4 * bf_pkg::BOX_SIZE / 2))
                state_next = bf_pkg::ST_OUT;
        end
    end

    assign out_valid = (state_reg == bf_pkg::ST_OUT);
    assign block_out = out_reg;
    assign status    = status_reg;

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output both open");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(block_out))
        else $error("stalled result changed");
    a_status_table: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> block_out == '0)
        else $error("rejected item carries data");
    a_ofb_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bf_pkg::ST_ROUND |=> $stable(ofb_reg))
        else $error("ofb register changed mid round");
`endif

endmodule
